FILE: rtl/core/cqlfd_pkg.sv
// Shared types, constants and a helper function of the frame deframer.
package cqlfd_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] COMPRESSION_FLAG = 8'h01;
  localparam logic [7:0] MAX_VERSION      = 8'd4;
  localparam logic [2:0] FIRST_WIDE_VER   = 3'd3;
  localparam logic [3:0] HDR_LEN_SHORT    = 4'd8;
  localparam logic [3:0] HDR_LEN_LONG     = 4'd9;

  localparam int unsigned TDATA_W = 80;
  localparam int unsigned TUSER_W = 2;

  // Header byte positions.
  localparam logic [3:0] IDX_VERSION   = 4'd0;
  localparam logic [3:0] IDX_FLAGS     = 4'd1;
  localparam logic [3:0] IDX_STREAM_HI = 4'd2;
  localparam logic [3:0] IDX_STREAM_LO = 4'd3;

  // Request opcodes accepted by the parser.
  localparam logic [7:0] OP_STARTUP       = 8'd1;
  localparam logic [7:0] OP_OPTIONS       = 8'd5;
  localparam logic [7:0] OP_QUERY         = 8'd7;
  localparam logic [7:0] OP_PREPARE       = 8'd9;
  localparam logic [7:0] OP_EXECUTE       = 8'd10;
  localparam logic [7:0] OP_REGISTER      = 8'd11;
  localparam logic [7:0] OP_BATCH         = 8'd13;
  localparam logic [7:0] OP_AUTH_RESPONSE = 8'd15;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_VERSION     = 2'd1,
    ERR_COMPRESSION = 2'd2,
    ERR_OPCODE      = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_body;
    logic        body_last;
    logic        header_done;
    logic [2:0]  frame_version;
    logic [7:0]  frame_flags;
    logic [15:0] stream_id;
    logic [7:0]  frame_opcode;
    logic [31:0] body_length;
    logic [1:0]  error_code;
  } res_t;

  function automatic logic opcode_ok(input logic [7:0] op);
    logic ok;
    case (op)
      OP_STARTUP, OP_OPTIONS, OP_QUERY, OP_PREPARE,
      OP_EXECUTE, OP_REGISTER, OP_BATCH, OP_AUTH_RESPONSE: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/core/cqlfd_parser.sv
// Front end: accepts request bytes, tracks header and body position, builds result words.
module cqlfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              space_i,
  output logic              push_o,
  output cqlfd_pkg::res_t   res_o
);

  logic [2:0]      ver_q, ver_d;
  logic [3:0]      idx_q, idx_d;
  logic [7:0]      hver_q, hver_d;
  logic [7:0]      flags_q, flags_d;
  logic [15:0]     stream_q, stream_d;
  logic [7:0]      opcode_q, opcode_d;
  logic [31:0]     length_q, length_d;
  logic [31:0]     rem_q, rem_d;
  cqlfd_pkg::err_e err_q, err_d;

  logic       accept;
  logic [7:0] b;
  logic       first;
  logic [2:0] ver_eff;
  logic       wide;
  logic [3:0] hlen;
  logic [3:0] idx_nxt;
  logic       is_body, body_last, header_done;

  assign s_axis_tready = space_i;
  assign accept        = s_axis_tvalid & space_i;
  assign push_o        = accept;
  assign b             = s_axis_tdata;

  always_comb begin
    ver_d       = ver_q;
    idx_d       = idx_q;
    hver_d      = hver_q;
    flags_d     = flags_q;
    stream_d    = stream_q;
    opcode_d    = opcode_q;
    length_d    = length_q;
    rem_d       = rem_q;
    err_d       = err_q;
    is_body     = 1'b0;
    body_last   = 1'b0;
    header_done = 1'b0;
    first       = (idx_q == cqlfd_pkg::IDX_VERSION) && (ver_q == 3'd0);
    ver_eff     = first ? b[2:0] : ver_q;
    wide        = ver_eff >= cqlfd_pkg::FIRST_WIDE_VER;
    hlen        = wide ? cqlfd_pkg::HDR_LEN_LONG : cqlfd_pkg::HDR_LEN_SHORT;
    idx_nxt     = idx_q + 4'd1;

    if (err_q == cqlfd_pkg::ERR_NONE) begin
      if (rem_q != 32'd0) begin
        is_body   = 1'b1;
        rem_d     = rem_q - 32'd1;
        body_last = (rem_q == 32'd1);
      end else if (first && (b == 8'd0 || b > cqlfd_pkg::MAX_VERSION)) begin
        // A first byte outside the supported versions sets the sticky version error at once.
        hver_d = b;
        err_d  = cqlfd_pkg::ERR_VERSION;
      end else begin
        ver_d = ver_eff;
        if (idx_q == cqlfd_pkg::IDX_VERSION) begin
          hver_d = b;
        end else if (idx_q == cqlfd_pkg::IDX_FLAGS) begin
          flags_d = b;
        end else if (idx_q == cqlfd_pkg::IDX_STREAM_HI) begin
          stream_d = {8'd0, b};
        end else if (wide && idx_q == cqlfd_pkg::IDX_STREAM_LO) begin
          stream_d = {stream_q[7:0], b};
        end else if (idx_q == (wide ? 4'd4 : 4'd3)) begin
          opcode_d = b;
        end else if (idx_q == (wide ? 4'd5 : 4'd4)) begin
          length_d = {24'd0, b};
        end else begin
          length_d = {length_q[23:0], b};
        end

        if (idx_nxt >= hlen) begin
          // The completing byte is always a length byte, so the other fields are settled.
          idx_d = 4'd0;
          if (hver_q != {5'd0, ver_q}) begin
            err_d = cqlfd_pkg::ERR_VERSION;
          end else if ((flags_q & cqlfd_pkg::COMPRESSION_FLAG) != 8'd0) begin
            err_d = cqlfd_pkg::ERR_COMPRESSION;
          end else if (!cqlfd_pkg::opcode_ok(opcode_q)) begin
            err_d = cqlfd_pkg::ERR_OPCODE;
          end else begin
            header_done = 1'b1;
            rem_d       = length_d;
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
    end
  end

  always_comb begin
    res_o.out_byte      = b;
    res_o.is_body       = is_body;
    res_o.body_last     = body_last;
    res_o.header_done   = header_done;
    res_o.frame_version = ver_d;
    res_o.frame_flags   = flags_d;
    res_o.stream_id     = stream_d;
    res_o.frame_opcode  = opcode_d;
    res_o.body_length   = length_d;
    res_o.error_code    = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q    <= 3'd0;
      idx_q    <= 4'd0;
      hver_q   <= 8'd0;
      flags_q  <= 8'd0;
      stream_q <= 16'd0;
      opcode_q <= 8'd0;
      length_q <= 32'd0;
      rem_q    <= 32'd0;
      err_q    <= cqlfd_pkg::ERR_NONE;
    end else if (accept) begin
      ver_q    <= ver_d;
      idx_q    <= idx_d;
      hver_q   <= hver_d;
      flags_q  <= flags_d;
      stream_q <= stream_d;
      opcode_q <= opcode_d;
      length_q <= length_d;
      rem_q    <= rem_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: rtl/core/cqlfd_fifo.sv
// Short result queue between the parser and the output stage.
module cqlfd_fifo #(
  parameter int unsigned Depth = cqlfd_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cqlfd_pkg::res_t wdata_i,
  output logic            space_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cqlfd_pkg::res_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cqlfd_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign space_o = (cnt_q != Full);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ((wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? ((rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/cqlfd_out.sv
// Back end: output register that presents result words on the master stream.
module cqlfd_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cqlfd_pkg::res_t res_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output cqlfd_pkg::res_t res_o
);

  logic            valid_q, valid_d;
  cqlfd_pkg::res_t res_q;

  // Take the next word whenever the register is empty or being drained.
  assign pop_o         = valid_i & (~valid_q | m_axis_tready);
  assign valid_d       = pop_o | (valid_q & ~m_axis_tready);
  assign m_axis_tvalid = valid_q;
  assign res_o         = res_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

FILE: rtl/core/cql_frame_deframer.sv
// A byte accepted on the slave side passes through the result queue and the output register.
// Throughput: one byte per cycle while the queue has space; the parser state updates in the cycle of acceptance.
// A result queue (FifoDepth words, at least 2) decouples the parser from the output register;
// when a stall has filled it, the input resumes in the cycle after the master side moves again.
// Reset is asynchronous and active low; it clears the version, header position, body
// count and sticky error, and empties the queue and the output register.
module cql_frame_deframer #(
  parameter int unsigned FifoDepth = cqlfd_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [10:8] frame_version, [18:11] frame_flags, [34:19] stream_id,
  // [42:35] frame_opcode, [74:43] body_length, [76:75] error_code, [79:77] zero
  output logic [cqlfd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // body_last
  output logic [cqlfd_pkg::TUSER_W-1:0] m_axis_tuser   // [0] is_body, [1] header_done
);

  cqlfd_pkg::res_t parse_res;
  cqlfd_pkg::res_t fifo_res;
  cqlfd_pkg::res_t out_res;
  logic            push;
  logic            space;
  logic            fifo_valid;
  logic            pop;

  cqlfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .space_i       (space),
    .push_o        (push),
    .res_o         (parse_res)
  );

  cqlfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (parse_res),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_res)
  );

  cqlfd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (fifo_valid),
    .res_i         (fifo_res),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.error_code, out_res.body_length, out_res.frame_opcode,
                         out_res.stream_id, out_res.frame_flags, out_res.frame_version,
                         out_res.out_byte};
  assign m_axis_tlast = out_res.body_last;
  assign m_axis_tuser = {out_res.header_done, out_res.is_body};

endmodule
